>>> src/osrb_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the overwriting sample ring buffer.
// Used by the channel interfaces and by the core; depends on nothing.
package osrb_pkg;

  // Field widths fixed by the item format
  localparam int CAP_W  = 11;
  localparam int OFFS_W = 10;
  localparam int ACT_W  = 2;

  // Configuration port
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  // Register index, taken from the word address bit
  localparam logic REG_CAPACITY = 1'b0;

  // Capacity after reset
  localparam int CAP_RESET = 1024;

  typedef enum logic [ACT_W-1:0] {
    ACT_PUSH = 2'd0,
    ACT_READ = 2'd1,
    ACT_POP  = 2'd2,
    ACT_NOP  = 2'd3
  } action_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_READ = 1'b1
  } state_t;

endpackage

>>> src/osrb_if.sv
`timescale 1ns / 1ps
// Request and result channels of the ring buffer, valid/ready handshake.
// Depends on osrb_pkg for the action type and the field widths.
interface osrb_cmd_if #(
  parameter int SAMPLE_BITS = 32
) ();
  logic                        valid;
  logic                        ready;
  osrb_pkg::action_t           action;
  logic [SAMPLE_BITS-1:0]      sample_in;
  logic [osrb_pkg::CAP_W-1:0]  window_length;
  logic [osrb_pkg::OFFS_W-1:0] offset;

  modport source (output valid, action, sample_in, window_length, offset, input ready);
  modport sink   (input valid, action, sample_in, window_length, offset, output ready);
endinterface

interface osrb_res_if #(
  parameter int SAMPLE_BITS = 32
) ();
  logic                       valid;
  logic                       ready;
  logic [SAMPLE_BITS-1:0]     sample_out;
  logic                       read_valid;
  logic [osrb_pkg::CAP_W-1:0] occupancy;
  logic                       is_full;

  modport source (output valid, sample_out, read_valid, occupancy, is_full, input ready);
  modport sink   (input valid, sample_out, read_valid, occupancy, is_full, output ready);
endinterface

>>> src/osrb_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Stands alone; no package needed.
module osrb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> src/overwriting_sample_ring_buffer_core.sv
`timescale 1ns / 1ps
// Top level of the overwriting sample ring buffer.
// Depends on osrb_pkg, the channel interfaces in osrb_if and osrb_ram.
//
// Usage:
// - Requests arrive on cmd (valid/ready); each request gives one result on res.
//   A push stores sample_in; once the store holds capacity samples, a push
//   overwrites the oldest one. A read returns the sample at offset from the
//   oldest one when the window fits the occupancy, else read_valid is low and
//   sample_out is zero. A pop drops up to window_length of the oldest samples.
//   Every result carries the occupancy and full status after the request.
// - Push, pop and no-operation requests, and reads whose window does not fit,
//   load the output register at the edge that accepts them. A valid read first
//   waits in the READ state for the registered read port of the sample RAM.
// - A new request is taken while a result waits, as long as that result is
//   taken in the same cycle; the output register holds a result while res
//   is stalled, and no request is accepted until it leaves.
// - Reset empties the store and sets capacity to 1024 (or DEPTH if smaller).
//   Writing the capacity register over APB also empties the store. The RAM
//   itself is not cleared; only occupied entries are ever read.
module overwriting_sample_ring_buffer_core #(
  parameter int DEPTH       = 1024,
  parameter int SAMPLE_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  osrb_cmd_if.sink                      cmd,
  osrb_res_if.source                    res,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [osrb_pkg::APB_AW-1:0]   paddr,
  input  logic [osrb_pkg::APB_DW-1:0]   pwdata,
  output logic [osrb_pkg::APB_DW-1:0]   prdata,
  output logic                          pready
);
  import osrb_pkg::*;

  localparam int PTR_W  = $clog2(DEPTH);
  localparam int CALC_W = ((PTR_W > CAP_W) ? PTR_W : CAP_W) + 1;
  localparam int CAP_USED_RESET = (CAP_RESET > DEPTH) ? DEPTH : CAP_RESET;
  localparam logic [CALC_W-1:0] DEPTH_C = CALC_W'(DEPTH);

  // Control and pointer registers
  state_t              state, state_next;
  logic [PTR_W-1:0]    wp, wp_next;
  logic [PTR_W-1:0]    rp, rp_next;
  logic [CALC_W-1:0]   level, level_next;
  logic [CAP_W-1:0]    capacity;
  logic [CALC_W-1:0]   cap_used, cap_used_next;

  // Result register
  logic                   res_valid, res_valid_next;
  logic [SAMPLE_BITS-1:0] res_sample;
  logic                   res_rvalid;
  logic [CAP_W-1:0]       res_occ;
  logic                   res_full;

  logic                   cmd_ready;
  logic                   cmd_fire;
  logic                   cfg_wr;
  logic                   res_load;
  logic                   res_load_data;
  logic                   rd_ok;
  logic                   ram_we;
  logic [PTR_W-1:0]       ram_raddr;
  logic [SAMPLE_BITS-1:0] ram_rdata;

  logic [CALC_W-1:0] wp_ext, rp_ext, wlen_ext, offs_ext;
  logic [CALC_W-1:0] wp_inc, rp_sum, pos, pop_n;
  logic [CALC_W-1:0] cfg_cap;

  assign cmd_fire = cmd.valid && cmd_ready;
  assign cfg_wr   = psel && penable && pwrite && (paddr[2] == REG_CAPACITY);

  // APB: always ready, reads of the capacity register return the raw capacity value, other addresses read zero
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_CAPACITY) ? APB_DW'(capacity) : '0;

  // Sample store
  osrb_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wp),
    .wdata (cmd.sample_in),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Next state of the sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (cmd_fire && (cmd.action == ACT_READ) && rd_ok) begin
          state_next = ST_READ;
        end
      end
      ST_READ: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    cmd_ready     = 1'b0;
    res_load_data = 1'b0;
    unique case (state)
      ST_IDLE: cmd_ready     = !res_valid || res.ready;
      ST_READ: res_load_data = 1'b1;
      default: cmd_ready     = 1'b0;
    endcase
  end

  // Zero-extended operands for pointer arithmetic
  always_comb begin
    wp_ext   = CALC_W'(wp);
    rp_ext   = CALC_W'(rp);
    wlen_ext = CALC_W'(cmd.window_length);
    offs_ext = CALC_W'(cmd.offset);
  end

  // Read window check and address of the requested sample
  always_comb begin
    rd_ok = (cmd.window_length != '0) && (wlen_ext <= level) &&
            (CAP_W'(cmd.offset) < cmd.window_length);
    pos = rp_ext + offs_ext;
    if (pos >= cap_used) begin
      pos = pos - cap_used;
    end
    ram_raddr = PTR_W'(pos);
  end

  // Pointer and level update for push and pop
  always_comb begin
    wp_next  = wp;
    rp_next  = rp;
    level_next = level;
    ram_we   = 1'b0;
    wp_inc   = wp_ext + CALC_W'(1);
    if (wp_inc >= cap_used) begin
      wp_inc = '0;
    end
    pop_n  = (wlen_ext < level) ? wlen_ext : level;
    rp_sum = rp_ext + pop_n;
    if (rp_sum >= cap_used) begin
      rp_sum = rp_sum - cap_used;
    end
    if (cmd_fire) begin
      case (cmd.action)
        ACT_PUSH: begin
          ram_we  = 1'b1;
          wp_next = PTR_W'(wp_inc);
          if ((cap_used - level) <= CALC_W'(1)) begin
            // Store full after this push; if it was already full, the oldest sample is overwritten
            rp_next    = PTR_W'(wp_inc);
            level_next = cap_used;
          end else begin
            level_next = level + CALC_W'(1);
          end
        end
        ACT_POP: begin
          rp_next    = PTR_W'(rp_sum);
          level_next = level - pop_n;
        end
        default: begin
        end
      endcase
    end
  end

  // Capacity as used: zero acts as one, clamped to the store depth
  always_comb begin
    cfg_cap = CALC_W'(pwdata[CAP_W-1:0]);
    if (cfg_cap == '0) begin
      cfg_cap = CALC_W'(1);
    end
    if (cfg_cap > DEPTH_C) begin
      cfg_cap = DEPTH_C;
    end
    cap_used_next = cfg_wr ? cfg_cap : cap_used;
  end

  // Result register loads at once, except for a valid read which waits for RAM data
  always_comb begin
    res_load       = (cmd_fire && !((cmd.action == ACT_READ) && rd_ok)) || res_load_data;
    res_valid_next = res_valid;
    if (res_load) begin
      res_valid_next = 1'b1;
    end else if (res.ready) begin
      res_valid_next = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      wp        <= '0;
      rp        <= '0;
      level     <= '0;
      capacity  <= CAP_W'(CAP_RESET);
      cap_used  <= CALC_W'(CAP_USED_RESET);
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      res_valid <= res_valid_next;
      cap_used  <= cap_used_next;
      if (cfg_wr) begin
        // A capacity write empties the store
        capacity <= pwdata[CAP_W-1:0];
        wp       <= '0;
        rp       <= '0;
        level    <= '0;
      end else begin
        wp    <= wp_next;
        rp    <= rp_next;
        level <= level_next;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (res_load_data) begin
      res_sample <= ram_rdata;
      res_rvalid <= 1'b1;
      res_occ    <= CAP_W'(level);
      res_full   <= (level == cap_used);
    end else if (res_load) begin
      res_sample <= '0;
      res_rvalid <= 1'b0;
      res_occ    <= CAP_W'(level_next);
      res_full   <= (level_next == cap_used);
    end
  end

  assign cmd.ready      = cmd_ready;
  assign res.valid      = res_valid;
  assign res.sample_out = res_sample;
  assign res.read_valid = res_rvalid;
  assign res.occupancy  = res_occ;
  assign res.is_full    = res_full;

endmodule
